// File: hw/rtl/ogks_pkg.sv
// Shared types, constants and tables of the occupancy grid kernel splat.
package ogks_pkg;

    // Field widths of the input and result beats
    localparam int POS_W      = 16;
    localparam int READING_W  = 16;
    localparam int RC_W       = 8;
    localparam int CELL_W     = 7;
    localparam int COUNT_W    = 5;

    // Default map size
    localparam int MAP_WIDTH_DEF  = 200;
    localparam int MAP_HEIGHT_DEF = 200;

    // Signed grid coordinate, wide enough for any position at the default map size
    localparam int COORD_W = 13;

    // Likelihood (Q16, up to 100.0) and filter input widths
    localparam int P_W = 23;
    localparam int R_W = 25;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int N_CFG      = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_W_CENTER   = 3'd0,
        CFG_W_EDGE     = 3'd1,
        CFG_W_DIAGONAL = 3'd2,
        CFG_W_FAR_EDGE = 3'd3,
        CFG_W_KNIGHT   = 3'd4,
        CFG_W_CORNER   = 3'd5,
        CFG_BIAS       = 3'd6
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [N_CFG] = '{
        16'd8500, 16'd5155, 16'd3127, 16'd1149, 16'd698, 16'd156, 16'd51
    };

    // Reading thresholds and likelihood constants
    localparam logic signed [READING_W-1:0] READING_LOW  = 16'sd1000;
    localparam logic signed [READING_W-1:0] READING_HIGH = 16'sd12000;
    localparam logic [P_W-1:0] LIK_ONE  = 23'd65536;
    localparam logic [P_W-1:0] LIK_FULL = 23'd6553600;
    // ceil(2^20 / 15): exact quotient by 15 for distances up to 11000
    localparam logic [16:0] RECIP15 = 17'd69906;
    localparam logic [13:0] LIK_DIV = 14'd15;
    // floor(rem * 8192 / 15) for a remainder of the division by 15
    localparam logic [12:0] LIK_FRAC [16] = '{
        13'd0,    13'd546,  13'd1092, 13'd1638, 13'd2184, 13'd2730, 13'd3276, 13'd3822,
        13'd4369, 13'd4915, 13'd5461, 13'd6007, 13'd6553, 13'd7099, 13'd7645, 13'd0
    };

    // Filter constants
    localparam logic signed [R_W-1:0] R_THRESH = 25'sd131072;
    // ceil(2^10 / 5): exact quotient by 5 for values below 1024
    localparam logic [16:0] DIV5_RECIP = 17'd205;
    localparam logic [7:0]  CELL_MAX   = 8'd100;

    // Ten cells per metre on a Q8.8 position
    localparam logic signed [19:0] CELLS_PER_M = 20'sd10;
    localparam logic [18:0]        ROUND_HALF  = 19'd128;

    // Kernel neighbourhood
    localparam logic [2:0] KER_LAST   = 3'd4;
    localparam logic [2:0] KER_RADIUS = 3'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep1;
        logic prep2;
        logic sweep_step;
        logic clr_step;
        logic out_load;
    } t_ogks_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_read;
        logic sweep_last;
        logic pipe_busy;
        logic clr_last;
        logic out_free;
    } t_ogks_sts;

endpackage

// File: hw/rtl/ogks_in_if.sv
// Input channel of the occupancy grid kernel splat: handshake and item fields.
interface ogks_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      operation;
    logic signed [ogks_pkg::POS_W-1:0]         pos_x;
    logic signed [ogks_pkg::POS_W-1:0]         pos_y;
    logic signed [ogks_pkg::READING_W-1:0]     loop_reading;
    logic        [ogks_pkg::RC_W-1:0]          read_col;
    logic        [ogks_pkg::RC_W-1:0]          read_row;

    modport source (
        output valid, operation, pos_x, pos_y, loop_reading, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, loop_reading, read_col, read_row,
        output ready
    );
endinterface

// File: hw/rtl/ogks_out_if.sv
// Result channel of the occupancy grid kernel splat: handshake and result fields.
interface ogks_out_if;
    logic                               valid;
    logic                               ready;
    logic [ogks_pkg::CELL_W-1:0]        cell_value;
    logic [ogks_pkg::COUNT_W-1:0]       cells_updated;

    modport source (
        output valid, cell_value, cells_updated,
        input  ready
    );
    modport sink (
        input  valid, cell_value, cells_updated,
        output ready
    );
endinterface

// File: hw/rtl/ogks_ctrl.sv
// Controller of the occupancy grid kernel splat: sequences clearing, updates and reads.
module ogks_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ogks_pkg::t_ogks_sts   i_sts,
    output ogks_pkg::t_ogks_cmd   o_cmd
);
    import ogks_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP1,
        ST_PREP2,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PREP1;
                end
            end
            ST_PREP1: begin
                // A read item issues its map access here and is then finished.
                o_cmd.prep1 = 1'b1;
                n_state     = i_sts.op_read ? ST_FINISH : ST_PREP2;
            end
            ST_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register; the map is cleared first after every reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // At most one datapath operation is commanded in any cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.prep1, o_cmd.prep2, o_cmd.sweep_step,
                  o_cmd.clr_step, o_cmd.out_load}))
        else $error("more than one datapath command at once");

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    // An accepted beat is always followed by its preparation step.
    a_capture_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.prep1)
        else $error("accepted beat not prepared");

endmodule

// File: hw/rtl/ogks_dp.sv
// Datapath of the occupancy grid kernel splat: registers, map RAM and cell update pipeline.
module ogks_dp #(
    parameter int MAP_WIDTH  = ogks_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = ogks_pkg::MAP_HEIGHT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ogks_pkg::t_ogks_cmd                    i_cmd,
    output ogks_pkg::t_ogks_sts                    o_sts,
    input  logic                                   i_operation,
    input  logic signed [ogks_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [ogks_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [ogks_pkg::READING_W-1:0]  i_loop_reading,
    input  logic        [ogks_pkg::RC_W-1:0]       i_read_col,
    input  logic        [ogks_pkg::RC_W-1:0]       i_read_row,
    input  logic                                   i_cfg_wr_en,
    input  logic        [ogks_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [ogks_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    ogks_out_if.source                             o_res
);
    import ogks_pkg::*;

    localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(MAP_WIDTH);
    localparam int YW     = $clog2(MAP_HEIGHT);
    localparam logic signed [COORD_W-1:0] HALF_X = COORD_W'(MAP_WIDTH / 2);
    localparam logic signed [COORD_W-1:0] HALF_Y = COORD_W'(MAP_HEIGHT / 2);
    localparam logic signed [COORD_W-1:0] LIM_X  = COORD_W'(MAP_WIDTH);
    localparam logic signed [COORD_W-1:0] LIM_Y  = COORD_W'(MAP_HEIGHT);
    localparam logic [ADDR_W-1:0]         ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0]         ROW_STEP  = ADDR_W'(MAP_WIDTH);

    // Position in Q8.8 metres to a grid coordinate, rounded half away from zero
    function automatic logic signed [COORD_W-1:0] pos_to_cell(
        input logic signed [POS_W-1:0]   pos,
        input logic signed [COORD_W-1:0] half
    );
        logic signed [19:0]        prod;
        logic                      neg;
        logic [18:0]               mag;
        logic [18:0]               rnd;
        logic signed [COORD_W-1:0] c;
        prod = {{4{pos[POS_W-1]}}, pos} * CELLS_PER_M;
        neg  = prod[19];
        mag  = neg ? 19'(-prod) : prod[18:0];
        rnd  = (mag + ROUND_HALF) >> 8;
        c    = COORD_W'(rnd);
        return (neg ? -c : c) + half;
    endfunction

    // Configuration registers
    logic [CFG_DATA_W-1:0]       r_cfg [N_CFG];

    // Captured item
    logic                        r_op;
    logic signed [POS_W-1:0]     r_pos_x;
    logic signed [POS_W-1:0]     r_pos_y;
    logic signed [READING_W-1:0] r_loop;
    logic [RC_W-1:0]             r_rcol;
    logic [RC_W-1:0]             r_rrow;

    // Preparation results
    logic signed [COORD_W-1:0]   r_mx;
    logic signed [COORD_W-1:0]   r_my;
    logic                        r_lik_full;
    logic                        r_lik_zero;
    logic [13:0]                 r_ld;
    logic [9:0]                  r_lq;
    logic [P_W-1:0]              r_p;

    // Sweep counters and pipeline
    logic [2:0]                  r_kx;
    logic [2:0]                  r_ky;
    logic [COUNT_W-1:0]          r_count;
    logic                        r_s1_valid;
    logic [ADDR_W-1:0]           r_s1_addr;
    logic [CFG_DATA_W-1:0]       r_s1_w;
    logic                        r_s2_valid;
    logic [ADDR_W-1:0]           r_s2_addr;
    logic signed [R_W-1:0]       r_s2_r;
    logic [CELL_W-1:0]           r_s2_old;

    // Map RAM and its ports
    logic [CELL_W-1:0]           r_mem [DEPTH];
    logic [CELL_W-1:0]           r_rd_data;
    logic                        r_rd_oob;
    logic [ADDR_W-1:0]           r_clr_addr;

    // Output register
    logic                        r_out_valid;
    logic [CELL_W-1:0]           r_out_cell;
    logic [COUNT_W-1:0]          r_out_count;

    // Combinational values
    logic signed [COORD_W-1:0]   n_mx;
    logic signed [COORD_W-1:0]   n_my;
    logic                        n_lik_full;
    logic                        n_lik_zero;
    logic [13:0]                 n_ld;
    logic [30:0]                 lq_prod;
    logic [9:0]                  n_lq;
    logic [13:0]                 rem_full;
    logic [3:0]                  n_rem;
    logic [P_W-1:0]              n_p;
    logic signed [COORD_W-1:0]   sw_x;
    logic signed [COORD_W-1:0]   sw_y;
    logic                        sw_inb;
    logic [1:0]                  abs_x;
    logic [1:0]                  abs_y;
    logic [3:0]                  dist2;
    t_cfg_idx                    w_sel;
    logic [ADDR_W-1:0]           sw_addr;
    logic                        rd_in_map;
    logic [ADDR_W-1:0]           rd_op_addr;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [P_W+15:0]             w_prod;
    logic signed [R_W-1:0]       n_r;
    logic [16:0]                 inc_prod;
    logic [7:0]                  inc_sum;
    logic [CELL_W-1:0]           n_cell;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [CELL_W-1:0]           wr_data;

    // Grid cell of the sensor and likelihood class of the reading
    always_comb begin
        n_mx       = pos_to_cell(r_pos_x, HALF_X);
        n_my       = pos_to_cell(r_pos_y, HALF_Y);
        n_lik_full = (r_loop < READING_LOW);
        n_lik_zero = (r_loop > READING_HIGH);
        n_ld       = 14'(READING_HIGH - r_loop);
        lq_prod    = 31'(n_ld) * 31'(RECIP15);
        n_lq       = lq_prod[29:20];
    end

    // Likelihood in Q16 from quotient and remainder of the distance by 15, or zero or full out of range
    always_comb begin
        rem_full = r_ld - 14'(r_lq) * LIK_DIV;
        n_rem    = rem_full[3:0];
        if (r_lik_zero) begin
            n_p = '0;
        end else if (r_lik_full) begin
            n_p = LIK_FULL;
        end else begin
            n_p = LIK_ONE + {r_lq, 13'b0} + P_W'(LIK_FRAC[n_rem]);
        end
    end

    // Neighbourhood cell of the sweep, its bounds and its kernel weight
    always_comb begin
        sw_x   = r_mx + COORD_W'(r_kx) - COORD_W'(KER_RADIUS);
        sw_y   = r_my + COORD_W'(r_ky) - COORD_W'(KER_RADIUS);
        sw_inb = (sw_x >= 0) && (sw_x < LIM_X) && (sw_y >= 0) && (sw_y < LIM_Y);
        abs_x  = (r_kx >= KER_RADIUS) ? 2'(r_kx - KER_RADIUS) : 2'(KER_RADIUS - r_kx);
        abs_y  = (r_ky >= KER_RADIUS) ? 2'(r_ky - KER_RADIUS) : 2'(KER_RADIUS - r_ky);
        dist2  = {2'b0, abs_x} * {2'b0, abs_x} + {2'b0, abs_y} * {2'b0, abs_y};
        case (dist2)
            4'd0:    w_sel = CFG_W_CENTER;
            4'd1:    w_sel = CFG_W_EDGE;
            4'd2:    w_sel = CFG_W_DIAGONAL;
            4'd4:    w_sel = CFG_W_FAR_EDGE;
            4'd5:    w_sel = CFG_W_KNIGHT;
            default: w_sel = CFG_W_CORNER;
        endcase
        sw_addr = ADDR_W'(sw_x[XW-1:0]) + ADDR_W'(sw_y[YW-1:0]) * ROW_STEP;
    end

    // Read port: sweep cells, or the single cell of a read item
    always_comb begin
        rd_in_map  = (32'(r_rcol) < 32'(MAP_WIDTH)) && (32'(r_rrow) < 32'(MAP_HEIGHT));
        rd_op_addr = ADDR_W'(r_rcol) + ADDR_W'(r_rrow) * ROW_STEP;
        rd_en      = (i_cmd.sweep_step && sw_inb) || (i_cmd.prep1 && r_op && rd_in_map);
        rd_addr    = i_cmd.sweep_step ? sw_addr : rd_op_addr;
    end

    // Weighted likelihood less the bias
    always_comb begin
        w_prod = r_p * r_s1_w;
        n_r    = $signed({2'b00, w_prod[P_W+15:16]})
               - $signed({r_cfg[CFG_BIAS][CFG_DATA_W-1], r_cfg[CFG_BIAS], 8'b0});
    end

    // Filter rule: raise by r / 2.5 in whole units up to 100, or lower by one down to zero
    always_comb begin
        inc_prod = 17'(r_s2_r[23:15]) * DIV5_RECIP;
        inc_sum  = {1'b0, r_s2_old} + {1'b0, inc_prod[16:10]};
        if (r_s2_r > R_THRESH) begin
            n_cell = (inc_sum > CELL_MAX) ? CELL_W'(CELL_MAX) : inc_sum[CELL_W-1:0];
        end else begin
            n_cell = (r_s2_old == '0) ? '0 : r_s2_old - 1'b1;
        end
    end

    // Write port: clearing pass, or the cell leaving the pipeline
    always_comb begin
        wr_en   = i_cmd.clr_step || r_s2_valid;
        wr_addr = i_cmd.clr_step ? r_clr_addr : r_s2_addr;
        wr_data = i_cmd.clr_step ? '0 : n_cell;
    end

    // Map RAM
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
            r_kx        <= '0;
            r_ky        <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(N_CFG))) begin
                r_cfg[i_cfg_index] <= i_cfg_wr_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.prep2) begin
                r_kx    <= '0;
                r_ky    <= '0;
                r_count <= '0;
            end else begin
                if (i_cmd.sweep_step) begin
                    if (r_ky == KER_LAST) begin
                        r_ky <= '0;
                        r_kx <= r_kx + 1'b1;
                    end else begin
                        r_ky <= r_ky + 1'b1;
                    end
                end
                if (r_s2_valid) begin
                    r_count <= r_count + 1'b1;
                end
            end
            r_s1_valid <= i_cmd.sweep_step && sw_inb;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_loop  <= i_loop_reading;
            r_rcol  <= i_read_col;
            r_rrow  <= i_read_row;
        end
        if (i_cmd.prep1) begin
            r_mx       <= n_mx;
            r_my       <= n_my;
            r_lik_full <= n_lik_full;
            r_lik_zero <= n_lik_zero;
            r_ld       <= n_ld;
            r_lq       <= n_lq;
            r_rd_oob   <= !rd_in_map;
        end
        if (i_cmd.prep2) begin
            r_p <= n_p;
        end
        r_s1_addr <= sw_addr;
        r_s1_w    <= r_cfg[w_sel];
        r_s2_addr <= r_s1_addr;
        r_s2_r    <= n_r;
        r_s2_old  <= r_rd_data;
        if (i_cmd.out_load) begin
            r_out_cell  <= (r_op && !r_rd_oob) ? r_rd_data : '0;
            r_out_count <= r_op ? '0 : r_count;
        end
    end

    // Status and result channel
    assign o_sts.op_read    = r_op;
    assign o_sts.sweep_last = (r_kx == KER_LAST) && (r_ky == KER_LAST);
    assign o_sts.pipe_busy  = r_s1_valid || r_s2_valid;
    assign o_sts.clr_last   = (r_clr_addr == ADDR_LAST);
    assign o_sts.out_free   = !r_out_valid || o_res.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.cell_value    = r_out_cell;
    assign o_res.cells_updated = r_out_count;

    // Within one update a cell is never read while it is being written back.
    a_no_rmw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && r_s2_valid) |-> (rd_addr != r_s2_addr))
        else $error("map read and write back collide on one cell");

    // The clearing pass never overlaps a cell write back.
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> !r_s1_valid && !r_s2_valid)
        else $error("clearing pass overlaps the update pipeline");

    // A result is taken only once the pipeline has drained, with a sane count.
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_s1_valid && !r_s2_valid && (r_count <= COUNT_W'(25)))
        else $error("result loaded before the update finished");

endmodule

// File: hw/rtl/occupancy_grid_kernel_splat.sv
// Top level of the occupancy grid kernel splat: controller, datapath and ports.
// After reset the block first clears its MAP_WIDTH x MAP_HEIGHT map RAM, one
// cell per cycle, and takes no item until that is done; configuration writes
// are taken at any time. An update item then runs through the preparation of
// the grid cell and the likelihood, a sweep in which the 5x5 neighbourhood is
// streamed through a three-stage read, weight and write-back pipeline on the
// map RAM's one read and one write port, a drain of that pipeline and the load
// of the result once the output register is free. A read item issues its map
// access in its first preparation step and then loads its result. The result
// sits in an output register, so the next item is accepted while a finished
// result still waits to be taken.
module occupancy_grid_kernel_splat #(
    parameter int MAP_WIDTH  = ogks_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = ogks_pkg::MAP_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ogks_in_if.sink                             i_upd,
    ogks_out_if.source                          o_res,
    input  logic                                i_cfg_wr_en,
    input  logic [ogks_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ogks_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);
    import ogks_pkg::*;

    t_ogks_cmd cmd;
    t_ogks_sts sts;
    logic      in_ready;

    // Sequencer
    ogks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_upd.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_upd.ready = in_ready;

    // Arithmetic, map RAM and result register
    ogks_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_upd.operation),
        .i_pos_x        (i_upd.pos_x),
        .i_pos_y        (i_upd.pos_y),
        .i_loop_reading (i_upd.loop_reading),
        .i_read_col     (i_upd.read_col),
        .i_read_row     (i_upd.read_row),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_res          (o_res)
    );

endmodule
